// ===== hw/rtl/akx_pkg.sv =====
// AES-128 key expansion package: S-box, round constants, control struct and codes.
// Used by every module of the key expansion unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package akx_pkg;

  localparam int unsigned KeyWidth      = 128;
  localparam int unsigned WordWidth     = 32;
  localparam int unsigned RoundWidth    = 4;
  localparam int unsigned PosWidth      = 2;
  localparam int unsigned OutDataWidth  = 40;  // 4 + 2 + 32 packed, padded to bytes
  localparam logic [RoundWidth-1:0] LastRound = 4'd10;
  localparam logic [PosWidth-1:0]   LastPos   = 2'd3;

  // Datapath controls from the sequencer to the word core.
  typedef struct packed {
    logic       load;   // take a new key
    logic       step;   // produce the next schedule word
    logic       pass;   // round 0: key words go out unchanged
    logic       mix;    // first word of a round: apply rot/sub/rcon
    logic [7:0] rcon;
  } core_ctrl_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for rounds 1 to 10; round 0 never mixes.
  function automatic logic [7:0] rcon_f(input logic [RoundWidth-1:0] round);
    logic [7:0] rc;
    case (round)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes128_key_expansion_unit.sv =====
// AES-128 key expansion: one 128-bit key in, 44 schedule words out, one word per cycle
// while the output is not stalled. The first word is loaded into the output register
// on the first step after the key is taken; the next key is taken with word 43.
// Rate is set by the word-serial shift register: one schedule word per step.
// Reset (async, active low) empties the output register and idles the sequencer.
// Depends on akx_pkg, akx_word_core, akx_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module aes128_key_expansion_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // key_high[63:0], key_low[127:64]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // round_number[3:0], word_index[5:4],
                                       // schedule_word[37:6], zero[39:38]
  output logic         m_axis_tlast
);
  import akx_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                state_q;
  logic [RoundWidth-1:0] round_q;
  logic [PosWidth-1:0]   pos_q;
  logic                  out_free;
  logic                  advance;
  logic                  last_step;
  logic                  accept;
  logic [WordWidth-1:0]  word;
  core_ctrl_t            ctrl;

  assign advance       = (state_q == ST_RUN) && out_free;
  assign last_step     = (round_q == LastRound) && (pos_q == LastPos);
  assign s_axis_tready = (state_q == ST_IDLE) || (advance && last_step);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl.load = accept;
    ctrl.step = advance;
    ctrl.pass = (round_q == '0);
    ctrl.mix  = (round_q != '0) && (pos_q == '0);
    ctrl.rcon = rcon_f(round_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      pos_q   <= '0;
    end else begin
      if (accept) begin
        state_q <= ST_RUN;
        round_q <= '0;
        pos_q   <= '0;
      end else if (advance) begin
        if (last_step) begin
          state_q <= ST_IDLE;
        end
        pos_q <= pos_q + 1'b1;
        if (pos_q == LastPos) begin
          round_q <= round_q + 1'b1;
        end
      end
    end
  end

  akx_word_core u_core (
    .clk_i  (clk_i),
    .key_i  (s_axis_tdata),
    .ctrl_i (ctrl),
    .word_o (word)
  );

  akx_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .round_i (round_q),
    .pos_i   (pos_q),
    .word_i  (word),
    .last_i  (last_step),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (out_free),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  // Final word carries round 10, word 3.
  a_last_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == LastRound
                                       && m_axis_tdata[5:4] == LastPos)
    else $error("tlast on a word other than the final one");

  // A new key is only taken when idle or on the final step.
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && state_q == ST_RUN |-> advance && last_step)
    else $error("key accepted in the middle of a schedule");

  // Round counter never passes the last round while running.
  a_round_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> round_q <= LastRound)
    else $error("round counter out of range");

  // Nothing is produced while the output holds a stalled item.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("stalled output item changed");

endmodule

`default_nettype wire

// ===== hw/rtl/akx_word_core.sv =====
// Word-serial key schedule datapath: a four-word shift register, one word per step.
// Depends on akx_pkg (S-box, control struct).
`timescale 1ns / 1ps
`default_nettype none

module akx_word_core (
  input  wire                              clk_i,
  input  wire  [akx_pkg::KeyWidth-1:0]     key_i,   // {key_low, key_high}
  input  wire  akx_pkg::core_ctrl_t        ctrl_i,
  output logic [akx_pkg::WordWidth-1:0]    word_o
);
  import akx_pkg::*;

  // w_q[0] is the word four positions back, w_q[3] the newest one
  logic [WordWidth-1:0] w_q [4];
  logic [WordWidth-1:0] w_d [4];
  logic [WordWidth-1:0] rot;
  logic [WordWidth-1:0] g_word;
  logic [WordWidth-1:0] new_word;

  always_comb begin
    rot    = {w_q[3][23:0], w_q[3][31:24]};
    g_word = {Sbox[rot[31:24]] ^ ctrl_i.rcon, Sbox[rot[23:16]],
              Sbox[rot[15:8]], Sbox[rot[7:0]]};
    if (ctrl_i.pass) begin
      new_word = w_q[0];
    end else if (ctrl_i.mix) begin
      new_word = w_q[0] ^ g_word;
    end else begin
      new_word = w_q[0] ^ w_q[3];
    end
  end

  assign word_o = new_word;

  always_comb begin
    w_d = w_q;
    if (ctrl_i.load) begin
      w_d[0] = key_i[63:32];
      w_d[1] = key_i[31:0];
      w_d[2] = key_i[127:96];
      w_d[3] = key_i[95:64];
    end else if (ctrl_i.step) begin
      w_d[0] = w_q[1];
      w_d[1] = w_q[2];
      w_d[2] = w_q[3];
      w_d[3] = new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/akx_out_stage.sv =====
// Output register of the key expansion unit: holds one result item until taken.
// Depends on akx_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none

module akx_out_stage (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                load_i,
  input  wire  [akx_pkg::RoundWidth-1:0]     round_i,
  input  wire  [akx_pkg::PosWidth-1:0]       pos_i,
  input  wire  [akx_pkg::WordWidth-1:0]      word_i,
  input  wire                                last_i,
  input  wire                                ready_i,
  output logic                               valid_o,
  output logic                               free_o,
  output logic [akx_pkg::OutDataWidth-1:0]   data_o,
  output logic                               last_o
);
  import akx_pkg::*;

  logic                    valid_q, valid_d;
  logic [OutDataWidth-1:0] data_q;
  logic                    last_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {2'b00, word_i, pos_i, round_i};
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== bench/akx_schedule_checker.sv =====
// Scoreboard for the AES-128 key expansion unit: watches the key and word streams,
// builds its own S-box and round constants and predicts all 44 schedule words per key.
// Depends on akx_pkg for field widths only.
`timescale 1ns / 1ps

module akx_schedule_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          key_valid_i,
  input  wire          key_ready_i,
  input  wire  [127:0] key_data_i,    // key_high[63:0], key_low[127:64]
  input  wire          word_valid_i,
  input  wire          word_ready_i,
  input  wire  [39:0]  word_data_i,   // round_number[3:0], word_index[5:4],
                                      // schedule_word[37:6], zero[39:38]
  input  wire          word_last_i,
  output int           fail_count_o,
  output int           words_pending_o
);

  import akx_pkg::*;

  typedef struct packed {
    logic [RoundWidth-1:0] round;
    logic [PosWidth-1:0]   pos;
    logic [WordWidth-1:0]  word;
    logic                  last;
  } sched_word_t;

  sched_word_t sched_words_q [$];
  logic [7:0]  sbox_tbl [256];
  logic [7:0]  rcon_tbl [1:10];
  int          mismatch_cnt = 0;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from the GF(2^8) inverse plus the affine map; rcon by repeated doubling.
  initial begin : build_tables
    logic [7:0] inv;
    logic [7:0] rc;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      sbox_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      rcon_tbl[r] = rc;
      rc = gf_mul(rc, 8'h02);
    end
  end

  function automatic void expand_key_schedule(input logic [63:0] key_hi,
                                              input logic [63:0] key_lo);
    logic [31:0] w [44];
    logic [31:0] t;
    sched_word_t e;
    w[0] = key_hi[63:32];
    w[1] = key_hi[31:0];
    w[2] = key_lo[63:32];
    w[3] = key_lo[31:0];
    for (int r = 1; r <= 10; r++) begin
      t = w[4*r-1];
      t = {t[23:0], t[31:24]};
      t = {sbox_tbl[t[31:24]], sbox_tbl[t[23:16]], sbox_tbl[t[15:8]], sbox_tbl[t[7:0]]};
      t[31:24] ^= rcon_tbl[r];
      w[4*r] = w[4*r-4] ^ t;
      for (int i = 1; i < 4; i++)
        w[4*r+i] = w[4*r+i-4] ^ w[4*r+i-1];
    end
    for (int n = 0; n < 44; n++) begin
      e.round = RoundWidth'(n / 4);
      e.pos   = PosWidth'(n % 4);
      e.word  = w[n];
      e.last  = (n == 43);
      sched_words_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i) begin
    sched_word_t e;
    if (rst_ni) begin
      // older words leave before a newly taken key adds its own
      if (word_valid_i && word_ready_i) begin
        if (sched_words_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected word: round %0d pos %0d word %08h last %b", $realtime,
                     word_data_i[3:0], word_data_i[5:4], word_data_i[37:6], word_last_i);
        end else begin
          e = sched_words_q.pop_front();
          if (word_data_i[3:0] !== e.round || word_data_i[5:4] !== e.pos ||
              word_data_i[37:6] !== e.word || word_last_i !== e.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: word mismatch: exp round %0d pos %0d word %08h last %b, ",
                        "got %0d %0d %08h %b"},
                       $realtime, e.round, e.pos, e.word, e.last, word_data_i[3:0],
                       word_data_i[5:4], word_data_i[37:6], word_last_i);
          end
        end
      end
      if (key_valid_i && key_ready_i)
        expand_key_schedule(key_data_i[63:0], key_data_i[127:64]);
    end
    fail_count_o    <= mismatch_cnt;
    words_pending_o <= sched_words_q.size();
  end

endmodule

// ===== bench/aes128_key_expansion_unit_tb.sv =====
// Testbench top for the AES-128 key expansion unit: clock, reset, key stimulus and
// random output stalls; the verdict comes from akx_schedule_checker.
// Depends on aes128_key_expansion_unit, akx_schedule_checker, akx_pkg.
`timescale 1ns / 1ps

module aes128_key_expansion_unit_tb;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic [127:0] s_axis_tdata  = '0;      // key_high[63:0], key_low[127:64]
  logic         m_axis_tready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [39:0]  m_axis_tdata;            // round_number[3:0], word_index[5:4],
                                         // schedule_word[37:6], zero[39:38]
  logic         m_axis_tlast;
  int           fail_count;
  int           words_pending;
  int           snd_idle_pct = 0;
  int           rcv_idle_pct = 0;

  // {key_high, key_low}
  localparam logic [127:0] EdgeKeys [12] = '{
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
    128'hffff_ffff_ffff_ffff_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_ffff_ffff_ffff_ffff,
    128'h5555_5555_5555_5555_5555_5555_5555_5555,
    128'haaaa_aaaa_aaaa_aaaa_aaaa_aaaa_aaaa_aaaa,
    128'h2b7e_1516_28ae_d2a6_abf7_1588_09cf_4f3c,
    128'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f,
    128'h8000_0000_0000_0000_0000_0000_0000_0000,
    128'h0000_0000_0000_0001_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_8000_0000_0000_0000,
    128'h0000_0000_0000_0000_0000_0000_0000_0001
  };

  always #5 clk_i = ~clk_i;

  aes128_key_expansion_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  akx_schedule_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_valid_i     (s_axis_tvalid),
    .key_ready_i     (s_axis_tready),
    .key_data_i      (s_axis_tdata),
    .word_valid_i    (m_axis_tvalid),
    .word_ready_i    (m_axis_tready),
    .word_data_i     (m_axis_tdata),
    .word_last_i     (m_axis_tlast),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

  task automatic send_key(input logic [63:0] key_hi, input logic [63:0] key_lo);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {key_lo, key_hi};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_keys(input int count);
    for (int i = 0; i < count; i++)
      send_key({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // pending count is registered; stop sending, then poll it until no words are pending
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 18;
    rcv_idle_pct = 68;
    foreach (EdgeKeys[i]) send_key(EdgeKeys[i][127:64], EdgeKeys[i][63:0]);
    wait_drained();
    send_random_keys(130);

    snd_idle_pct = 68;
    rcv_idle_pct = 18;
    send_random_keys(134);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random_keys(134);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
